// ===== hw/rtl/irm_pkg.sv =====
package irm_pkg;

   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 8;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 7;
   localparam int ENTRY_W  = KEY_W + VALUE_W;

   localparam logic CMD_ASSIGN = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/irm_req_if.sv =====
interface irm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic signed [irm_pkg::KEY_W-1:0]    key_begin;
   logic signed [irm_pkg::KEY_W-1:0]    key_end;
   logic        [irm_pkg::VALUE_W-1:0]  new_value;

   modport source (output valid, command, key_begin, key_end, new_value, input ready);
   modport sink   (input valid, command, key_begin, key_end, new_value, output ready);
endinterface

// ===== hw/rtl/irm_rsp_if.sv =====
interface irm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [irm_pkg::VALUE_W-1:0]         found_value;
   logic [irm_pkg::STATUS_W-1:0]        status;
   logic [irm_pkg::USED_W-1:0]          entries_used;

   modport source (output valid, found_value, status, entries_used, input ready);
   modport sink   (input valid, found_value, status, entries_used, output ready);
endinterface

// ===== hw/rtl/irm_csr_if.sv =====
interface irm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [irm_pkg::VALUE_W-1:0]         data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/irm_ram.sv =====
module irm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== hw/rtl/interval_range_map_core.sv =====
// A lookup reads the breakpoints held in one pass; an assign reads them in a scan pass
// and again in a merge pass; an assign with an empty range goes straight to the result.
// One RAM read per cycle per pass, except while the merge writes the new range's bounds.
// One item at a time; a new request is taken while the previous result still waits.
// An assign compacts the table into the other half of the RAM and swaps halves on success.
// Synchronous reset clears the breakpoint count, the default value and the control state.
module interval_range_map_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   irm_req_if.sink   req_if,
   irm_rsp_if.source rsp_if,
   irm_csr_if.sink   csr_if
);
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int NN_W   = $clog2(TABLE_DEPTH + 3);
   localparam int ADDR_W = IDX_W + 1;
   localparam int KW     = irm_pkg::KEY_W;
   localparam int VW     = irm_pkg::VALUE_W;

   irm_pkg::state_type state_ff, state_in;

   logic                       bank_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [VW-1:0]              default_ff;
   logic                       cmd_ff;
   logic signed [KW-1:0]       kb_ff, ke_ff;
   logic [VW-1:0]              val_ff;
   logic [VW-1:0]              cur_val_ff;
   logic [CNT_W-1:0]           rd_idx_ff;
   logic                       head_valid_ff;
   logic                       b_done_ff, e_done_ff;
   logic [NN_W-1:0]            nn_ff;
   logic [VW-1:0]              nprev_ff;
   logic [VW-1:0]              found_ff;
   logic [irm_pkg::STATUS_W-1:0] status_ff;

   logic                       rsp_valid_ff;
   logic [VW-1:0]              rsp_found_ff;
   logic [irm_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [irm_pkg::USED_W-1:0] rsp_used_ff;

   logic [irm_pkg::ENTRY_W-1:0] rd_data;
   logic signed [KW-1:0]       head_key;
   logic [VW-1:0]              head_val;
   logic signed [KW-1:0]       target_key;

   logic                       accept, issue, consume, push_en, finish, rsp_load, empty_range;
   logic signed [KW-1:0]       push_key;
   logic [VW-1:0]              push_val;
   logic                       push_new, wr_en;
   logic [CNT_W+irm_pkg::USED_W-1:0] used_ext;

   assign head_key   = rd_data[irm_pkg::ENTRY_W-1:VW];
   assign head_val   = rd_data[VW-1:0];
   assign target_key = (cmd_ff == irm_pkg::CMD_LOOKUP) ? kb_ff : ke_ff;

   assign req_if.ready = (state_ff == irm_pkg::ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;
   assign empty_range  = (req_if.command == irm_pkg::CMD_ASSIGN) &&
                         !(req_if.key_begin < req_if.key_end);
   assign rsp_load     = (state_ff == irm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   assign push_new = push_en && (push_val != nprev_ff);
   assign wr_en    = push_new && (nn_ff < NN_W'(TABLE_DEPTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         irm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = empty_range ? irm_pkg::ST_DONE : irm_pkg::ST_SCAN;
            end
         end
         irm_pkg::ST_SCAN: begin
            if (finish) begin
               state_in = (cmd_ff == irm_pkg::CMD_LOOKUP) ? irm_pkg::ST_DONE
                                                          : irm_pkg::ST_MERGE;
            end
         end
         irm_pkg::ST_MERGE: begin
            if (finish) begin
               state_in = irm_pkg::ST_DONE;
            end
         end
         irm_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = irm_pkg::ST_IDLE;
            end
         end
         default: state_in = irm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      issue    = 1'b0;
      consume  = 1'b0;
      push_en  = 1'b0;
      push_key = kb_ff;
      push_val = val_ff;
      finish   = 1'b0;
      case (state_ff)
         irm_pkg::ST_SCAN: begin
            consume = head_valid_ff;
            issue   = rd_idx_ff < count_ff;
            finish  = !issue && !head_valid_ff;
         end
         irm_pkg::ST_MERGE: begin
            if (!b_done_ff) begin
               if (head_valid_ff && (head_key < kb_ff)) begin
                  consume  = 1'b1;
                  push_en  = 1'b1;
                  push_key = head_key;
                  push_val = head_val;
               end else if (head_valid_ff || (rd_idx_ff == count_ff)) begin
                  push_en = 1'b1;
               end
            end else if (!e_done_ff) begin
               push_en  = 1'b1;
               push_key = ke_ff;
               push_val = cur_val_ff;
            end else if (head_valid_ff) begin
               consume  = 1'b1;
               push_en  = head_key > ke_ff;
               push_key = head_key;
               push_val = head_val;
            end else begin
               finish = rd_idx_ff == count_ff;
            end
            issue = (rd_idx_ff < count_ff) && (!head_valid_ff || consume);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= irm_pkg::ST_IDLE;
         bank_ff       <= 1'b0;
         count_ff      <= '0;
         default_ff    <= '0;
         head_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid && csr_if.ready) begin
            default_ff <= csr_if.data;
         end
         if (issue) begin
            head_valid_ff <= 1'b1;
         end else if (consume) begin
            head_valid_ff <= 1'b0;
         end
         if (state_ff == irm_pkg::ST_MERGE && finish && nn_ff <= NN_W'(TABLE_DEPTH)) begin
            bank_ff  <= ~bank_ff;
            count_ff <= nn_ff[CNT_W-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_if.command;
         kb_ff      <= req_if.key_begin;
         ke_ff      <= req_if.key_end;
         val_ff     <= req_if.new_value;
         cur_val_ff <= default_ff;
         nprev_ff   <= default_ff;
         rd_idx_ff  <= '0;
         b_done_ff  <= 1'b0;
         e_done_ff  <= 1'b0;
         nn_ff      <= '0;
         found_ff   <= '0;
         status_ff  <= empty_range ? irm_pkg::STATUS_EMPTY : irm_pkg::STATUS_DONE;
      end else begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
         if (state_ff == irm_pkg::ST_SCAN) begin
            if (consume && (head_key <= target_key)) begin
               cur_val_ff <= head_val;
            end
            if (finish) begin
               rd_idx_ff <= '0;
            end
            if (finish && cmd_ff == irm_pkg::CMD_LOOKUP) begin
               found_ff <= cur_val_ff;
            end
         end
         if (state_ff == irm_pkg::ST_MERGE) begin
            if (push_en && !b_done_ff && !consume) begin
               b_done_ff <= 1'b1;
            end else if (push_en && b_done_ff && !e_done_ff) begin
               e_done_ff <= 1'b1;
            end
            if (push_new) begin
               nprev_ff <= push_val;
               if (nn_ff < NN_W'(TABLE_DEPTH + 2)) begin
                  nn_ff <= nn_ff + NN_W'(1);
               end
            end
            if (finish && nn_ff > NN_W'(TABLE_DEPTH)) begin
               status_ff <= irm_pkg::STATUS_FULL;
            end
         end
      end
      if (rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= status_ff;
         rsp_used_ff   <= used_ext[irm_pkg::USED_W-1:0];
      end
   end

   assign used_ext = {{irm_pkg::USED_W{1'b0}}, count_ff};

   irm_ram #(
      .WIDTH (irm_pkg::ENTRY_W),
      .DEPTH (2 ** ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({~bank_ff, nn_ff[IDX_W-1:0]}),
      .wr_data ({push_key, push_val}),
      .rd_en   (issue),
      .rd_addr (ADDR_W'({bank_ff, rd_idx_ff[IDX_W-1:0]})),
      .rd_data (rd_data)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found_value  = rsp_found_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.entries_used = rsp_used_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("breakpoint count above table depth");

   a_write_other_bank: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == irm_pkg::ST_MERGE)
      else $error("table write outside merge");

   a_nn_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == irm_pkg::ST_MERGE |-> nn_ff <= NN_W'(TABLE_DEPTH + 2))
      else $error("merge count overflow");

   a_idle_no_head: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == irm_pkg::ST_DONE) && $past(state_ff) == irm_pkg::ST_MERGE
      |-> !head_valid_ff)
      else $error("merge finished with unread entry");
endmodule
